@@ rtl/core/pgdw_pkg.sv @@
// Shared types, codes and helpers of the painless Gabor dual window unit.
package pgdw_pkg;

   // Configuration register indexes
   localparam logic [7:0] REG_WINDOW_LENGTH = 8'd0;
   localparam logic [7:0] REG_HOP_SIZE      = 8'd1;
   localparam logic [7:0] REG_CHANNEL_COUNT = 8'd2;
   localparam logic [7:0] REG_RESULT_MODE   = 8'd3;

   // Result modes
   localparam logic [1:0] MODE_DUAL  = 2'd0;
   localparam logic [1:0] MODE_TIGHT = 2'd1;
   localparam logic [1:0] MODE_POU   = 2'd2;

   // Status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_ARG   = 3'd1;
   localparam logic [2:0] STAT_NOT_FRAME = 3'd2;
   localparam logic [2:0] STAT_NOT_PAINL = 3'd3;
   localparam logic [2:0] STAT_ZERO_DIAG = 3'd4;
   localparam logic [2:0] STAT_NOT_READY = 3'd5;

   // Request kinds
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ACC_RD,
      ST_ACC_SQ,
      ST_ACC_WR,
      ST_RD_CAP,
      ST_RD_PREP,
      ST_NORM,
      ST_SQRT,
      ST_DIV_SET,
      ST_DIV,
      ST_DIV_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic compute;
      logic rd_issue;
      logic set_nr;
      logic set_err;
      logic clr_step;
      logic acc_issue;
      logic acc_square;
      logic acc_write;
      logic rd_cap;
      logic set_zero;
      logic norm_init;
      logic norm_step;
      logic sqrt_init;
      logic sqrt_step;
      logic div_load;
      logic div_step;
      logic set_sat;
      logic set_quo;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic cfg_ok;
      logic ready;
      logic err_set;
      logic clr_last;
      logic acc_last;
      logic sum_zero;
      logic mode_tight;
      logic norm_ok;
      logic sqrt_last;
      logic guard;
      logic div_last;
      logic rsp_free;
   } status_type;

   // Saturate a magnitude and apply the sign
   function automatic logic [31:0] sat32(input logic [63:0] q, input logic neg);
      logic [63:0] qc;
      begin
         if (neg) begin
            qc = (q > 64'h8000_0000) ? 64'h8000_0000 : q;
            sat32 = 32'd0 - qc[31:0];
         end else begin
            qc = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
            sat32 = qc[31:0];
         end
      end
   endfunction

endpackage

@@ rtl/core/painless_gabor_dual_window_unit.sv @@
// Top level of the painless Gabor dual window unit.
//
//   channel  dir  handshake            payload
//   req_     in   req_tvalid/tready    tdata sample, tuser func, tlast final_sample
//   rsp_     out  rsp_tvalid/tready    tdata out_value, tuser status, tlast last_out
//   csr_     in   csr_valid/ready      csr_index register index, csr_data value
//
// A load stores its sample; with a valid configuration the final load clears
// the diagonal memory and then runs the squared-sum pass (read, square, write).
// A read runs the serial divider in dual and partition-of-unity modes; in tight
// mode it first normalizes and takes the square root before dividing.
// Reset is synchronous; the finished result waits in the output register,
// so a stalled rsp_ side only holds the next read at its final step.
module painless_gabor_dual_window_unit
   import pgdw_pkg::*;
#(
   parameter int MAX_LEN = 1024,
   parameter int MAX_HOP = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] func
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   cmd_type    cmd;
   status_type stat;

   assign csr_ready = 1'b1;

   pgdw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_final  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pgdw_datapath #(
      .MAX_LEN (MAX_LEN),
      .MAX_HOP (MAX_HOP)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_sample (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/pgdw_ctrl.sv @@
// Controller state machine of the painless Gabor dual window unit.
module pgdw_ctrl
   import pgdw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_func,
   input  logic       req_final,
   output logic       req_tready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  if (req_final && stat.cfg_ok) state_in = ST_CLEAR;
               end else if (!stat.ready || stat.err_set) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_RD_CAP;
               end
            end
         end
         ST_CLEAR:   if (stat.clr_last) state_in = ST_ACC_RD;
         ST_ACC_RD:  state_in = ST_ACC_SQ;
         ST_ACC_SQ:  state_in = ST_ACC_WR;
         ST_ACC_WR:  state_in = stat.acc_last ? ST_IDLE : ST_ACC_RD;
         ST_RD_CAP:  state_in = ST_RD_PREP;
         ST_RD_PREP: begin
            if (stat.sum_zero)        state_in = ST_EMIT;
            else if (stat.mode_tight) state_in = ST_NORM;
            else                      state_in = ST_DIV;
         end
         ST_NORM:    if (stat.norm_ok) state_in = ST_SQRT;
         ST_SQRT:    if (stat.sqrt_last) state_in = ST_DIV_SET;
         ST_DIV_SET: state_in = stat.guard ? ST_EMIT : ST_DIV;
         ST_DIV:     if (stat.div_last) state_in = ST_DIV_END;
         ST_DIV_END: state_in = ST_EMIT;
         ST_EMIT:    if (stat.rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load    = 1'b1;
                  cmd.compute = req_final;
               end else if (!stat.ready) begin
                  cmd.set_nr = 1'b1;
               end else if (stat.err_set) begin
                  cmd.set_err = 1'b1;
               end else begin
                  cmd.rd_issue = 1'b1;
               end
            end
         end
         ST_CLEAR:   cmd.clr_step   = 1'b1;
         ST_ACC_RD:  cmd.acc_issue  = 1'b1;
         ST_ACC_SQ:  cmd.acc_square = 1'b1;
         ST_ACC_WR:  cmd.acc_write  = 1'b1;
         ST_RD_CAP:  cmd.rd_cap     = 1'b1;
         ST_RD_PREP: begin
            if (stat.sum_zero)        cmd.set_zero  = 1'b1;
            else if (stat.mode_tight) cmd.norm_init = 1'b1;
            else                      cmd.div_load  = 1'b1;
         end
         ST_NORM: begin
            if (stat.norm_ok) cmd.sqrt_init = 1'b1;
            else              cmd.norm_step = 1'b1;
         end
         ST_SQRT:    cmd.sqrt_step = 1'b1;
         ST_DIV_SET: begin
            if (stat.guard) cmd.set_sat  = 1'b1;
            else            cmd.div_load = 1'b1;
         end
         ST_DIV:     cmd.div_step = 1'b1;
         ST_DIV_END: cmd.set_quo  = 1'b1;
         ST_EMIT:    cmd.push     = stat.rsp_free;
         default:    cmd = '0;
      endcase
   end

endmodule

@@ rtl/core/pgdw_datapath.sv @@
// Datapath: registers, window and diagonal memories, square, root and divide units.
module pgdw_datapath
   import pgdw_pkg::*;
#(
   parameter int MAX_LEN = 1024,
   parameter int MAX_HOP = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic [15:0] req_sample,
   input  cmd_type     cmd,
   output status_type  stat,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int SW = (MAX_HOP > 1) ? $clog2(MAX_HOP) : 1;

   // Configuration and latched copies
   logic [10:0] cfg_len_ff, lat_len_ff;
   logic [8:0]  cfg_hop_ff, lat_hop_ff;
   logic [15:0] cfg_chan_ff, lat_chan_ff;
   logic [1:0]  cfg_mode_ff, lat_mode_ff;
   logic [2:0]  err_ff, err_in;
   logic        ready_ff;

   // Indexes
   logic [LW-1:0] load_idx_ff;
   logic [AW-1:0] rd_idx_ff, acc_ii_ff;
   logic [SW-1:0] rd_slot_ff, acc_slot_ff, half_slot_ff, clr_idx_ff;
   logic          acc_down_ff;
   logic [11:0]   half;

   // Memories and read registers
   logic [15:0] win_mem [MAX_LEN];
   logic [47:0] diag_mem [MAX_HOP];
   logic [15:0] win_q_ff;
   logic [47:0] diag_q_ff;
   logic [AW-1:0] win_raddr;
   logic [SW-1:0] diag_raddr;

   // Arithmetic registers
   logic [15:0] mag, mag_ff;
   logic [31:0] sq_ff, sqm_ff;
   logic        neg_ff, last_ff, sum_zero_ff;
   logic [63:0] den_ff, nx_ff;
   logic [4:0]  k_ff;
   logic [63:0] sx_ff, sr_ff, sb_ff, s_trial;
   logic [63:0] dq_ff, dr_ff, dd_ff, div_n, div_d;
   logic [64:0] div_r2;
   logic        div_ge;
   logic [5:0]  dcnt_ff, tsh, gsh;
   logic        res_neg;

   // Result and output registers
   logic [31:0] res_val_ff;
   logic [2:0]  res_stat_ff;
   logic        res_last_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;
   logic        rsp_last_ff;

   // Argument checks on the live registers
   always_comb begin
      if (cfg_len_ff == 11'd0 || cfg_hop_ff == 9'd0 || cfg_chan_ff == 16'd0 ||
          32'(cfg_len_ff) > 32'(MAX_LEN) || 32'(cfg_hop_ff) > 32'(MAX_HOP)) begin
         err_in = STAT_BAD_ARG;
      end else if (!(32'(cfg_chan_ff) > 32'(cfg_hop_ff) &&
                     32'(cfg_len_ff) >= 32'(cfg_hop_ff))) begin
         err_in = STAT_NOT_FRAME;
      end else if (32'(cfg_chan_ff) < 32'(cfg_len_ff)) begin
         err_in = STAT_NOT_PAINL;
      end else begin
         err_in = STAT_OK;
      end
   end

   assign half = (12'(lat_len_ff) + 12'd1) >> 1;
   assign mag  = win_q_ff[15] ? (16'd0 - win_q_ff) : win_q_ff;

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s, input logic [8:0] hop);
      begin
         slot_inc = (32'(s) + 1 == 32'(hop)) ? '0 : s + 1'b1;
      end
   endfunction

   // Hold configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff  <= 11'd16;
         cfg_hop_ff  <= 9'd4;
         cfg_chan_ff <= 16'd16;
         cfg_mode_ff <= MODE_DUAL;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_LENGTH: cfg_len_ff  <= csr_data[10:0];
            REG_HOP_SIZE:      cfg_hop_ff  <= csr_data[8:0];
            REG_CHANNEL_COUNT: cfg_chan_ff <= csr_data;
            REG_RESULT_MODE:   cfg_mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Latch the computation setup
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_len_ff  <= '0;
         lat_hop_ff  <= '0;
         lat_chan_ff <= '0;
         lat_mode_ff <= '0;
         err_ff      <= STAT_OK;
      end else if (cmd.compute) begin
         lat_len_ff  <= cfg_len_ff;
         lat_hop_ff  <= cfg_hop_ff;
         lat_chan_ff <= cfg_chan_ff;
         lat_mode_ff <= cfg_mode_ff;
         err_ff      <= err_in;
      end
   end

   // Track load, read and ready state
   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff <= '0;
         rd_idx_ff   <= '0;
         rd_slot_ff  <= '0;
         ready_ff    <= 1'b0;
      end else begin
         if (cmd.compute) begin
            load_idx_ff <= '0;
         end else if (cmd.load && 32'(load_idx_ff) < 32'(MAX_LEN)) begin
            load_idx_ff <= load_idx_ff + 1'b1;
         end
         if (cmd.load) begin
            rd_idx_ff  <= '0;
            rd_slot_ff <= '0;
            ready_ff   <= cmd.compute;
         end else if (cmd.set_err) begin
            ready_ff <= 1'b0;
         end else if (cmd.rd_issue) begin
            if (32'(rd_idx_ff) + 1 >= 32'(lat_len_ff)) begin
               rd_idx_ff  <= '0;
               rd_slot_ff <= '0;
               ready_ff   <= 1'b0;
            end else begin
               rd_idx_ff  <= rd_idx_ff + 1'b1;
               rd_slot_ff <= (32'(rd_idx_ff) + 1 == 32'(half)) ? half_slot_ff :
                             slot_inc(rd_slot_ff, lat_hop_ff);
            end
         end
      end
   end

   // Walk the window: front half upward, back half downward
   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         acc_ii_ff   <= '0;
         acc_slot_ff <= '0;
         acc_down_ff <= 1'b0;
         clr_idx_ff  <= '0;
      end else begin
         if (cmd.clr_step) clr_idx_ff <= clr_idx_ff + 1'b1;
         if (cmd.acc_write) begin
            if (!acc_down_ff) begin
               if (32'(acc_ii_ff) + 1 == 32'(half)) begin
                  acc_down_ff <= 1'b1;
                  acc_ii_ff   <= AW'(lat_len_ff - 11'd1);
                  acc_slot_ff <= SW'(lat_hop_ff - 9'd1);
               end else begin
                  acc_ii_ff   <= acc_ii_ff + 1'b1;
                  acc_slot_ff <= slot_inc(acc_slot_ff, lat_hop_ff);
               end
            end else begin
               if (32'(acc_ii_ff) == 32'(half)) begin
                  half_slot_ff <= acc_slot_ff;
               end else begin
                  acc_ii_ff   <= acc_ii_ff - 1'b1;
                  acc_slot_ff <= (acc_slot_ff == '0) ? SW'(lat_hop_ff - 9'd1) :
                                 acc_slot_ff - 1'b1;
               end
            end
         end
      end
   end

   assign win_raddr  = cmd.acc_issue ? acc_ii_ff : rd_idx_ff;
   assign diag_raddr = cmd.acc_issue ? acc_slot_ff : rd_slot_ff;

   // Window memory
   always_ff @(posedge clock) begin
      if (cmd.load && 32'(load_idx_ff) < 32'(MAX_LEN)) begin
         win_mem[load_idx_ff[AW-1:0]] <= req_sample;
      end
      if (cmd.acc_issue || cmd.rd_issue) begin
         win_q_ff <= win_mem[win_raddr];
      end
   end

   // Diagonal memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         diag_mem[clr_idx_ff] <= '0;
      end else if (cmd.acc_write) begin
         diag_mem[acc_slot_ff] <= diag_q_ff + 48'(sq_ff);
      end
      if (cmd.acc_issue || cmd.rd_issue) begin
         diag_q_ff <= diag_mem[diag_raddr];
      end
   end

   // Square, capture and scale
   always_ff @(posedge clock) begin
      if (cmd.acc_square) sq_ff <= mag * mag;
      if (cmd.rd_issue) last_ff <= (32'(rd_idx_ff) + 1 >= 32'(lat_len_ff));
      if (cmd.rd_cap) begin
         mag_ff      <= mag;
         neg_ff      <= win_q_ff[15];
         sqm_ff      <= mag * mag;
         den_ff      <= 64'(lat_chan_ff) * 64'(diag_q_ff);
         sum_zero_ff <= (diag_q_ff == '0);
      end
   end

   // Normalize and take the square root, one step per cycle
   assign s_trial = sr_ff + sb_ff;
   always_ff @(posedge clock) begin
      if (cmd.norm_init) begin
         nx_ff <= den_ff;
         k_ff  <= '0;
      end else if (cmd.norm_step) begin
         nx_ff <= nx_ff << 2;
         k_ff  <= k_ff + 1'b1;
      end
      if (cmd.sqrt_init) begin
         sx_ff <= nx_ff;
         sr_ff <= '0;
         sb_ff <= 64'h1 << 60;
      end else if (cmd.sqrt_step) begin
         if (sx_ff >= s_trial) begin
            sx_ff <= sx_ff - s_trial;
            sr_ff <= (sr_ff >> 1) + sb_ff;
         end else begin
            sr_ff <= sr_ff >> 1;
         end
         sb_ff <= sb_ff >> 2;
      end
   end

   assign tsh     = 6'd24 + 6'(k_ff);
   assign gsh     = 6'd63 - tsh;
   assign res_neg = (lat_mode_ff == MODE_POU) ? 1'b0 : neg_ff;

   // Select dividend and divisor by mode
   always_comb begin
      case (lat_mode_ff)
         MODE_TIGHT: begin
            div_n = (64'(mag_ff) << tsh) + (sr_ff >> 1);
            div_d = sr_ff;
         end
         MODE_POU: begin
            div_n = (64'(sqm_ff) << 24) + (den_ff >> 1);
            div_d = den_ff;
         end
         default: begin
            div_n = (64'(mag_ff) << 39) + (den_ff >> 1);
            div_d = den_ff;
         end
      endcase
   end

   // Restoring divider, one quotient bit per cycle
   assign div_r2 = {dr_ff, dq_ff[63]};
   assign div_ge = div_r2 >= {1'b0, dd_ff};
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dq_ff   <= div_n;
         dd_ff   <= div_d;
         dr_ff   <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dr_ff   <= div_ge ? 64'(div_r2 - {1'b0, dd_ff}) : div_r2[63:0];
         dq_ff   <= {dq_ff[62:0], div_ge};
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // Form the pending result
   always_ff @(posedge clock) begin
      if (cmd.set_nr) begin
         res_val_ff  <= '0;
         res_stat_ff <= STAT_NOT_READY;
         res_last_ff <= 1'b0;
      end else if (cmd.set_err) begin
         res_val_ff  <= '0;
         res_stat_ff <= err_ff;
         res_last_ff <= 1'b1;
      end else if (cmd.set_zero) begin
         res_val_ff  <= 32'h7FFF_FFFF;
         res_stat_ff <= STAT_ZERO_DIAG;
         res_last_ff <= last_ff;
      end else if (cmd.set_sat) begin
         res_val_ff  <= sat32('1, neg_ff);
         res_stat_ff <= STAT_OK;
         res_last_ff <= last_ff;
      end else if (cmd.set_quo) begin
         res_val_ff  <= sat32(dq_ff, res_neg);
         res_stat_ff <= STAT_OK;
         res_last_ff <= last_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.push) begin
         rsp_data_ff <= res_val_ff;
         rsp_user_ff <= res_stat_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Status to the controller
   always_comb begin
      stat            = '0;
      stat.cfg_ok     = (err_in == STAT_OK);
      stat.ready      = ready_ff;
      stat.err_set    = (err_ff != STAT_OK);
      stat.clr_last   = (32'(clr_idx_ff) + 1 >= 32'(lat_hop_ff));
      stat.acc_last   = acc_down_ff ? (32'(acc_ii_ff) == 32'(half)) :
                        (32'(acc_ii_ff) + 1 == 32'(half) &&
                         32'(lat_len_ff) - 1 < 32'(half));
      stat.sum_zero   = sum_zero_ff;
      stat.mode_tight = (lat_mode_ff == MODE_TIGHT);
      stat.norm_ok    = (nx_ff[63:60] != 4'd0);
      stat.sqrt_last  = sb_ff[0];
      stat.guard      = ((32'(mag_ff) >> gsh) != 32'd0);
      stat.div_last   = (dcnt_ff == 6'd63);
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule
